FILE: rtl/slcp_pkg.sv
// ----------------------------------------------------------------------------
// slcp_pkg: shared constants for the serial line command parser
// Character codes and default sizing.
// ----------------------------------------------------------------------------
package slcp_pkg;

   localparam int LINE_CAPACITY_DEFAULT = 32;

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_COLON = 8'd58;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_VT    = 8'd11;
   localparam logic [7:0] CHAR_FF    = 8'd12;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   // shortest well formed line: letter, colon, one more byte
   localparam int MIN_LINE_LENGTH = 3;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7fff_ffff;

endpackage

FILE: rtl/serial_line_command_parser.sv
// ----------------------------------------------------------------------------
// serial_line_command_parser
// Builds lines from received bytes and reports "X:<number>" commands. One byte
// is taken per cycle while the input stage advances: each beat lands in an
// input register, from which a single pass of logic updates the line state
// (command letter, colon check, atoi-style argument with 32-bit saturation)
// and, on CR or LF after a non-empty line, loads one result beat into the
// output register. Bytes past LINE_CAPACITY-1 in a line are dropped. The
// rate is one byte per clock when not stalled; the input stage advances
// whenever the output register is empty or being taken, so a stalled result
// holds off at most the byte behind it. Results pass input then output register.
// ----------------------------------------------------------------------------
module serial_line_command_parser
   import slcp_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] command_letter, [39:8] argument_value,
                                    // [40] value_overflowed, [47:41] zero
   output logic [0:0]  rsp_tuser    // [0] well_formed
);

   localparam int CW = $clog2(LINE_CAPACITY);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(LINE_CAPACITY - 1);

   typedef enum logic [1:0] {
      PH_BLANKS,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // input stage
   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          advance;

   // line state
   logic [CW-1:0] count_ff,  count_in;
   logic [7:0]    first_ff,  first_in;
   logic          colon_ff,  colon_in;
   phase_type     phase_ff,  phase_in;
   logic          minus_ff,  minus_in;
   logic [31:0]   mag_ff,    mag_in;
   logic          ovf_ff,    ovf_in;

   // result register
   logic          out_valid_ff, out_valid_in;
   logic          out_wf_ff,    out_wf_in;
   logic [7:0]    out_letter_ff, out_letter_in;
   logic [31:0]   out_value_ff,  out_value_in;
   logic          out_ovf_ff,    out_ovf_in;

   logic          is_term, is_digit, is_blank, is_sign;
   logic [35:0]   mag_next;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   assign is_term  = (in_byte_ff == CHAR_CR) || (in_byte_ff == CHAR_LF);
   assign is_digit = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign is_blank = (in_byte_ff == CHAR_SPACE) || (in_byte_ff == CHAR_TAB) ||
                     (in_byte_ff == CHAR_VT) || (in_byte_ff == CHAR_FF);
   assign is_sign  = (in_byte_ff == CHAR_PLUS) || (in_byte_ff == CHAR_MINUS);

   // magnitude * 10 + digit, as shift-and-add
   assign mag_next = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0}
                   + {32'd0, 4'(in_byte_ff - CHAR_ZERO)};

   always_comb begin
      count_in      = count_ff;
      first_in      = first_ff;
      colon_in      = colon_ff;
      phase_in      = phase_ff;
      minus_in      = minus_ff;
      mag_in        = mag_ff;
      ovf_in        = ovf_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_wf_in     = out_wf_ff;
      out_letter_in = out_letter_ff;
      out_value_in  = out_value_ff;
      out_ovf_in    = out_ovf_ff;

      if (in_valid_ff && advance) begin
         if (is_term) begin
            if (count_ff != '0) begin
               out_valid_in = 1'b1;
               if ((count_ff >= CW'(MIN_LINE_LENGTH)) && colon_ff) begin
                  out_wf_in     = 1'b1;
                  out_letter_in = first_ff;
                  out_ovf_in    = ovf_ff;
                  if (minus_ff) begin
                     out_value_in = 32'd0 - mag_ff;
                  end else if (mag_ff > POS_MAX) begin
                     out_value_in = POS_MAX;
                     out_ovf_in   = 1'b1;
                  end else begin
                     out_value_in = mag_ff;
                  end
               end else begin
                  out_wf_in     = 1'b0;
                  out_letter_in = '0;
                  out_value_in  = '0;
                  out_ovf_in    = 1'b0;
               end
               count_in = '0;
               first_in = '0;
               colon_in = 1'b0;
               phase_in = PH_BLANKS;
               minus_in = 1'b0;
               mag_in   = '0;
               ovf_in   = 1'b0;
            end
         end else if (count_ff < COUNT_LIMIT) begin
            count_in = count_ff + CW'(1);
            if (count_ff == '0) begin
               first_in = in_byte_ff;
            end else if (count_ff == CW'(1)) begin
               colon_in = (in_byte_ff == CHAR_COLON);
            end else begin
               case (phase_ff)
                  PH_BLANKS: begin
                     if (is_sign) begin
                        minus_in = (in_byte_ff == CHAR_MINUS);
                        phase_in = PH_DIGITS;
                     end else if (is_digit) begin
                        phase_in = PH_DIGITS;
                        mag_in   = mag_next[31:0];
                     end else if (!is_blank) begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_DIGITS: begin
                     if (is_digit) begin
                        if (mag_next > {4'd0, MAG_CAP}) begin
                           mag_in = MAG_CAP;
                           ovf_in = 1'b1;
                        end else begin
                           mag_in = mag_next[31:0];
                        end
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
               // first digit straight from blanks cannot overflow
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         first_ff     <= '0;
         colon_ff     <= 1'b0;
         phase_ff     <= PH_BLANKS;
         minus_ff     <= 1'b0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         colon_ff     <= colon_in;
         phase_ff     <= phase_in;
         minus_ff     <= minus_in;
         mag_ff       <= mag_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      out_wf_ff     <= out_wf_in;
      out_letter_ff <= out_letter_in;
      out_value_ff  <= out_value_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ovf_ff, out_value_ff, out_letter_ff};
   assign rsp_tuser  = out_wf_ff;

endmodule
